### sv/csm_pkg.sv
// Shared types, constants and the case-fold function for the substring matcher.
`timescale 1ns / 1ps

package csm_pkg;

	localparam int CFG_DATA_BITS  = 64;
	localparam int CFG_INDEX_BITS = 3;
	localparam int LEN_REG_BITS   = 6;
	localparam int PATTERN_BYTES  = 32;
	localparam int PATTERN_BITS   = PATTERN_BYTES * 8;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_PATTERN_0_7    = 3'd1,
		REG_PATTERN_8_15   = 3'd2,
		REG_PATTERN_16_23  = 3'd3,
		REG_PATTERN_24_31  = 3'd4
	} cfg_reg_t;

	// Fold A-Z to a-z; every other code passes unchanged.
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'h20;
		end
		return c;
	endfunction

endpackage

### sv/csm_window_compare.sv
// Parallel case-insensitive compare of the text window against the pattern.
`timescale 1ns / 1ps

module csm_window_compare #(
	parameter int MAX_PATTERN = 32,
	parameter int LEN_BITS    = 6
) (
	input  logic [MAX_PATTERN*8-1:0]      text_win,   // byte 0 newest
	input  logic [csm_pkg::PATTERN_BITS-1:0] pattern,
	input  logic [LEN_BITS-1:0]           pat_len,    // already clamped to MAX_PATTERN
	output logic                          hit
);
	import csm_pkg::*;

	localparam int SH_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic [SH_BITS-1:0]     shift_amt;
	logic [7:0]             want [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] pos_ok;

	// Age k of the window lines up with pattern byte len-1-k.
	assign shift_amt = SH_BITS'(MAX_PATTERN - int'(pat_len));

	always_comb begin
		for (int k = 0; k < MAX_PATTERN; k++) begin
			if (k + int'(shift_amt) < MAX_PATTERN) begin
				want[k] = fold_case(pattern[8*(MAX_PATTERN-1-k-int'(shift_amt)) +: 8]);
			end else begin
				want[k] = 8'h00;
			end
			pos_ok[k] = (k >= int'(pat_len)) || (fold_case(text_win[8*k +: 8]) == want[k]);
		end
	end

	assign hit = (pat_len != '0) && (&pos_ok);

endmodule

### sv/case_insensitive_substring_matcher.sv
// Top level: case-insensitive substring search over a byte stream.
`timescale 1ns / 1ps

// Usage
//   Text channel: text_valid/text_ready carry one beat per text byte, with
//   text_end set on the last byte of a text.
//   Result channel: result_valid/result_ready carry one beat per text byte:
//   match_found, match_start, match_count and text_done (copy of text_end).
//   Config port: cfg_we writes cfg_data to register cfg_index at the clock
//   edge (0 length, 1..4 pattern words); other indexes are ignored. Write
//   only while no text beat is in flight.
//   Path from text beat to result beat: input register, then compare and
//   result register. Throughput: one byte per cycle while result_ready is
//   high; the window compare is fully parallel, so nothing iterates.
//   Stall: the input stage keeps accepting while a result waits, up to one
//   held byte; text_ready falls only when both stages are full.
//   Reset (arst_n low): pattern, window, position and count clear at once;
//   no clearing pass. After the result of an end-of-text byte the window,
//   position and count clear again, the pattern is kept.
module case_insensitive_substring_matcher #(
	parameter int MAX_PATTERN   = 32,
	parameter int POSITION_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [csm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [csm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	// text beats
	input  logic                                text_valid,
	output logic                                text_ready,
	input  logic [7:0]                          text_byte,
	input  logic                                text_end,
	// result beats
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                match_found,
	output logic [POSITION_BITS-1:0]            match_start,
	output logic [POSITION_BITS-1:0]            match_count,
	output logic                                text_done
);
	import csm_pkg::*;

	localparam int LEN_BITS  = $clog2(MAX_PATTERN + 1);
	localparam int WIN_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	// configuration registers
	logic [LEN_REG_BITS-1:0] pat_len_q;
	logic [PATTERN_BITS-1:0] pat_q;
	logic [LEN_BITS-1:0]     len_eff;

	// text state: recent bytes (newest first), next position, running count
	logic [7:0]               recent_q [WIN_DEPTH];
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] count_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       adv_s1;

	// result stage
	logic                     valid_s2;
	logic                     found_s2;
	logic [POSITION_BITS-1:0] start_s2;
	logic [POSITION_BITS-1:0] count_s2;
	logic                     done_s2;

	logic [MAX_PATTERN*8-1:0] text_win;
	logic                     cmp_hit;
	logic                     long_enough;
	logic                     hit;
	logic [POSITION_BITS-1:0] start_pos;
	logic [POSITION_BITS-1:0] count_next;

	// Over-long lengths clamp to the window size.
	assign len_eff = (int'(pat_len_q) > MAX_PATTERN) ? LEN_BITS'(MAX_PATTERN)
	                                                 : LEN_BITS'(pat_len_q);

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len_q <= '0;
			pat_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LENGTH: pat_len_q <= cfg_data[LEN_REG_BITS-1:0];
				REG_PATTERN_0_7:    pat_q[0   +: CFG_DATA_BITS] <= cfg_data;
				REG_PATTERN_8_15:   pat_q[64  +: CFG_DATA_BITS] <= cfg_data;
				REG_PATTERN_16_23:  pat_q[128 +: CFG_DATA_BITS] <= cfg_data;
				REG_PATTERN_24_31:  pat_q[192 +: CFG_DATA_BITS] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage handshake: s1 moves on when the result register is free or drains.
	assign adv_s1     = valid_s1 && (!valid_s2 || result_ready);
	assign text_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && text_ready) begin
			byte_s1 <= text_byte;
			end_s1  <= text_end;
		end
	end

	// Window as seen by the byte in s1: age 0 is the byte itself.
	always_comb begin
		text_win[7:0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			text_win[8*k +: 8] = recent_q[k-1];
		end
	end

	csm_window_compare #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_BITS    (LEN_BITS)
	) u_cmp (
		.text_win (text_win),
		.pattern  (pat_q),
		.pat_len  (len_eff),
		.hit      (cmp_hit)
	);

	// At least len bytes seen, counting this one.
	assign long_enough = ({1'b0, pos_q} + 1'b1) >= (POSITION_BITS+1)'(len_eff);
	assign hit         = cmp_hit && long_enough;
	assign start_pos   = pos_q - POSITION_BITS'(len_eff) + 1'b1;
	assign count_next  = (hit && count_q != POS_MAX) ? count_q + 1'b1 : count_q;

	// Text state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			count_q <= '0;
			for (int k = 0; k < WIN_DEPTH; k++) begin
				recent_q[k] <= 8'h00;
			end
		end else if (adv_s1) begin
			if (end_s1) begin
				pos_q   <= '0;
				count_q <= '0;
				for (int k = 0; k < WIN_DEPTH; k++) begin
					recent_q[k] <= 8'h00;
				end
			end else begin
				count_q <= count_next;
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 1'b1;
				end
				if (MAX_PATTERN > 1) begin
					for (int k = WIN_DEPTH - 1; k > 0; k--) begin
						recent_q[k] <= recent_q[k-1];
					end
					recent_q[0] <= byte_s1;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			found_s2 <= hit;
			start_s2 <= hit ? start_pos : '0;
			count_s2 <= count_next;
			done_s2  <= end_s1;
		end
	end

	assign result_valid = valid_s2;
	assign match_found  = found_s2;
	assign match_start  = start_s2;
	assign match_count  = count_s2;
	assign text_done    = done_s2;

`ifndef ASSERT_OFF
	a_found_counted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && found_s2 |-> count_s2 != '0)
		else $error("match reported with zero count");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && end_s1 |=> pos_q == '0 && count_q == '0)
		else $error("text state not cleared after final byte");

	a_empty_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && pat_len_q == '0 |-> !hit)
		else $error("empty pattern matched");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> valid_s1 && valid_s2 && !result_ready)
		else $error("text_ready low with room in the pipeline");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !end_s1 |=> count_q >= $past(count_q))
		else $error("match count went down within a text");
`endif

endmodule

### verif/case_insensitive_substring_matcher_test.sv
// Self-checking testbench: directed table followed by random texts.
`timescale 1ns / 1ps

// Every text beat is fed to a predictor that keeps its own window, position
// and count. The expectation is queued when the beat is accepted. Result beats
// are compared field by field with the oldest one waiting.
// Idling goes through three phases: sender gaps with a busy receiver, the
// reverse, then none at all.
module case_insensitive_substring_matcher_test;
	import csm_pkg::*;

	localparam int MAX_PATTERN   = 32;
	localparam int POSITION_BITS = 20;
	localparam int unsigned POS_LIMIT = (1 << POSITION_BITS) - 1;
	localparam int RANDOM_BEATS  = 145;                        // per idling phase

	typedef struct packed {
		logic                     found;
		logic [POSITION_BITS-1:0] start;
		logic [POSITION_BITS-1:0] count;
		logic                     done;
	} match_rec_t;

	// One row of the directed table: a new pattern, or a text beat with an
	// optional expectation written out by hand.
	typedef struct packed {
		logic                     reprogram;
		logic [CFG_DATA_BITS-1:0] len_word;
		logic [PATTERN_BITS-1:0]  pat;
		logic [7:0]               b;
		logic                     last;
		logic                     typed;
		match_rec_t               want;
	} step_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      cfg_we       = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;
	logic                      text_valid   = 1'b0;
	logic                      text_ready;
	logic [7:0]                text_byte    = '0;
	logic                      text_end     = 1'b0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic                      match_found;
	logic [POSITION_BITS-1:0]  match_start;
	logic [POSITION_BITS-1:0]  match_count;
	logic                      text_done;

	// hand-written expectation, travelling alongside the beat it belongs to
	logic       typed_on  = 1'b0;
	match_rec_t typed_rec = '0;

	int gap_pct     = 17;
	int stall_pct   = 50;
	int fault_count = 0;

	match_rec_t pending_results [$];

	// predictor state
	logic [LEN_REG_BITS-1:0]  len_reg;
	logic [CFG_DATA_BITS-1:0] pat_word [PATTERN_BYTES / 8];
	logic [7:0]               seen [MAX_PATTERN - 1];   // most recent byte first
	int unsigned              text_pos;
	int unsigned              hits;

	case_insensitive_substring_matcher #(
		.MAX_PATTERN  (MAX_PATTERN),
		.POSITION_BITS(POSITION_BITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.text_valid  (text_valid),
		.text_ready  (text_ready),
		.text_byte   (text_byte),
		.text_end    (text_end),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.match_found (match_found),
		.match_start (match_start),
		.match_count (match_count),
		.text_done   (text_done)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("case_insensitive_substring_matcher verification failed");
		$finish;
	end

	// Receiver: stalls at random, per cycle, whatever the block is doing.
	always @(posedge clk) begin
		result_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic report_fault(input string what);
		fault_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? (c | 8'h20) : c;
	endfunction

	// Flip the case of a letter half the time; anything else passes.
	function automatic logic [7:0] swap_case(input logic [7:0] c);
		if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
			return $urandom_range(0, 1) ? (c ^ 8'h20) : c;
		end
		return c;
	endfunction

	function automatic logic [7:0] pat_byte(input int k);
		return pat_word[k / 8][8 * (k % 8) +: 8];
	endfunction

	task automatic clear_text();
		foreach (seen[i]) begin
			seen[i] = '0;
		end
		text_pos = 0;
		hits     = 0;
	endtask

	// Predict the result of one text byte and advance the text state.
	task automatic scan_byte(input logic [7:0] b, input logic last, output match_rec_t r);
		int unsigned span;
		logic        hit;
		span = (len_reg > MAX_PATTERN) ? MAX_PATTERN : len_reg;
		hit  = 1'b0;
		// an occurrence ending here needs span bytes of text so far
		if (span > 0 && text_pos + 1 >= span) begin
			hit = to_lower(b) == to_lower(pat_byte(span - 1));
			for (int j = 1; j < span; j++) begin
				if (to_lower(seen[j - 1]) != to_lower(pat_byte(span - 1 - j))) begin
					hit = 1'b0;
				end
			end
		end
		r = '0;
		if (hit) begin
			// text_pos may be pinned at its ceiling; start follows from that
			r.start = POSITION_BITS'(text_pos - (span - 1));
			if (hits < POS_LIMIT) begin
				hits++;
			end
		end
		r.found = hit;
		r.count = POSITION_BITS'(hits);
		r.done  = last;
		if (last) begin
			clear_text();
		end else begin
			for (int i = MAX_PATTERN - 2; i > 0; i--) begin
				seen[i] = seen[i - 1];
			end
			seen[0] = b;
			if (text_pos < POS_LIMIT) begin
				text_pos++;
			end
		end
	endtask

	// Expectations are queued at the accepting edge; results are checked at
	// theirs. Prediction goes first so a same-edge result would still match.
	always @(posedge clk) begin : watch
		match_rec_t calc;
		match_rec_t got;
		match_rec_t want;
		if (arst_n && text_valid && text_ready) begin
			scan_byte(text_byte, text_end, calc);
			pending_results = {pending_results, (typed_on ? typed_rec : calc)};
		end
		if (arst_n && result_valid && result_ready) begin
			got = {match_found, match_start, match_count, text_done};
			if (pending_results.size() == 0) begin
				report_fault("result beat with nothing outstanding");
			end else begin
				want = pending_results.pop_front();
				if (got.found != want.found) begin
					report_fault($sformatf("match_found %0d, want %0d", got.found, want.found));
				end
				if (got.start != want.start) begin
					report_fault($sformatf("match_start %0d, want %0d", got.start, want.start));
				end
				if (got.count != want.count) begin
					report_fault($sformatf("match_count %0d, want %0d", got.count, want.count));
				end
				if (got.done != want.done) begin
					report_fault($sformatf("text_done %0d, want %0d", got.done, want.done));
				end
			end
		end
	end

	// Leaves cfg_we high; the caller lowers it once the group of writes is done.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_PATTERN_LENGTH: len_reg     = data[LEN_REG_BITS-1:0];
			REG_PATTERN_0_7:    pat_word[0] = data;
			REG_PATTERN_8_15:   pat_word[1] = data;
			REG_PATTERN_16_23:  pat_word[2] = data;
			REG_PATTERN_24_31:  pat_word[3] = data;
			default: ;
		endcase
	endtask

	task automatic program_pattern(input logic [CFG_DATA_BITS-1:0] len_word,
			input logic [PATTERN_BITS-1:0] pat);
		for (int w = 0; w < PATTERN_BYTES / 8; w++) begin
			write_reg(CFG_INDEX_BITS'(int'(REG_PATTERN_0_7) + w), pat[CFG_DATA_BITS * w +: CFG_DATA_BITS]);
		end
		// one stray write to an index with nothing behind it
		write_reg(CFG_INDEX_BITS'($urandom_range(int'(REG_PATTERN_24_31) + 1,
			(1 << CFG_INDEX_BITS) - 1)), {$urandom, $urandom});
		write_reg(REG_PATTERN_LENGTH, len_word);
		cfg_we <= 1'b0;
	endtask

	// Offer one beat and hold it until taken. Valid is only dropped for a gap,
	// so back-to-back beats keep it high without a glitch.
	task automatic push_text(input logic [7:0] b, input logic last, input logic typed,
			input match_rec_t want);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte  <= b;
		text_end   <= last;
		typed_on   <= typed;
		typed_rec  <= want;
		do begin
			@(posedge clk);
		end while (!text_ready);
	endtask

	// Stop offering beats and wait for every outstanding result.
	task automatic settle();
		int waited;
		text_valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending_results.size() != 0 && waited < 2000);
		if (pending_results.size() != 0) begin
			report_fault($sformatf("%0d results never arrived", pending_results.size()));
			pending_results.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic step_t row_beat(input logic [7:0] b, input logic last);
		step_t s;
		s      = '0;
		s.b    = b;
		s.last = last;
		return s;
	endfunction

	function automatic step_t row_known(input logic [7:0] b, input logic last,
			input logic found, input int unsigned start, input int unsigned count);
		step_t s;
		s            = row_beat(b, last);
		s.typed      = 1'b1;
		s.want.found = found;
		s.want.start = POSITION_BITS'(start);
		s.want.count = POSITION_BITS'(count);
		s.want.done  = last;
		return s;
	endfunction

	function automatic step_t row_cfg(input logic [CFG_DATA_BITS-1:0] len_word,
			input logic [PATTERN_BITS-1:0] pat);
		step_t s;
		s           = '0;
		s.reprogram = 1'b1;
		s.len_word  = len_word;
		s.pat       = pat;
		return s;
	endfunction

	// One pattern setting and a run of text under it. Most bytes come from
	// planted occurrences with mixed case or from pattern letters (so partial
	// and overlapping matches turn up); the rest are arbitrary bytes.
	task automatic random_session(input int beats);
		logic [CFG_DATA_BITS-1:0] len_word;
		logic [PATTERN_BITS-1:0]  pat;
		logic [7:0]               b;
		logic                     last;
		int                       span;
		int                       plant;
		int                       end_pct;
		len_word = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0:       len_word[LEN_REG_BITS-1:0] = '0;
			1:       len_word[LEN_REG_BITS-1:0] = LEN_REG_BITS'(1);
			2:       len_word[LEN_REG_BITS-1:0] = LEN_REG_BITS'(MAX_PATTERN);
			3:       len_word[LEN_REG_BITS-1:0] = LEN_REG_BITS'($urandom_range(MAX_PATTERN + 1, 63));
			4:       len_word[LEN_REG_BITS-1:0] = LEN_REG_BITS'($urandom_range(9, MAX_PATTERN - 1));
			default: len_word[LEN_REG_BITS-1:0] = LEN_REG_BITS'($urandom_range(2, 6));
		endcase
		span = (len_word[LEN_REG_BITS-1:0] > MAX_PATTERN) ? MAX_PATTERN
			: int'(len_word[LEN_REG_BITS-1:0]);
		for (int w = 0; w < PATTERN_BITS / 32; w++) begin
			pat[32 * w +: 32] = $urandom;
		end
		// small alphabet of a/b in both cases, so occurrences overlap
		for (int k = 0; k < span; k++) begin
			if ($urandom_range(0, 9) != 0) begin
				pat[8 * k +: 8] = ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 1));
			end
		end
		settle();
		program_pattern(len_word, pat);
		plant   = span;
		end_pct = (span > 16) ? 1 : 4;
		repeat (beats) begin
			if (plant >= span && span > 0 && $urandom_range(0, 99) < 25) begin
				plant = 0;
			end
			if (plant < span) begin
				b = swap_case(pat[8 * plant +: 8]);
				plant++;
			end else if (span == 0 || $urandom_range(0, 99) < 15) begin
				b = 8'($urandom_range(0, 255));
			end else begin
				b = swap_case(pat[8 * $urandom_range(0, span - 1) +: 8]);
			end
			last = $urandom_range(0, 99) < end_pct;
			push_text(b, last, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int send_gap, input int recv_stall);
		int left;
		int chunk;
		gap_pct   = send_gap;
		stall_pct = recv_stall;
		left      = RANDOM_BEATS;
		while (left > 0) begin
			chunk = $urandom_range(30, 60);
			if (chunk > left) begin
				chunk = left;
			end
			random_session(chunk);
			left -= chunk;
		end
	endtask

	initial begin : stimulus
		step_t plan [$];
		clear_text();
		len_reg = '0;
		foreach (pat_word[w]) begin
			pat_word[w] = '0;
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Patterns are packed lowest byte first, so 16'h4161
		// is "aA".
		plan = '{
			// reset state: empty pattern, even a zero byte never matches
			row_known(8'h00, 1'b0, 1'b0, 0, 0),
			row_known(8'hFF, 1'b1, 1'b0, 0, 0),
			row_cfg(64'h2, 256'h4161),
			row_known(8'h41, 1'b0, 1'b0, 0, 0),   // too few bytes yet
			row_known(8'h61, 1'b0, 1'b1, 0, 1),
			row_known(8'h41, 1'b0, 1'b1, 1, 2),   // overlapping occurrence
			// codes just outside the letter ranges are not folded
			row_beat(8'h40, 1'b0),
			row_beat(8'h5B, 1'b0),
			row_beat(8'h60, 1'b0),
			row_beat(8'h7B, 1'b0),
			row_known(8'h61, 1'b1, 1'b0, 0, 2),
			row_known(8'h61, 1'b0, 1'b0, 0, 0),   // window cleared by the last beat
			row_beat(8'h5A, 1'b1),
			// length register takes the low six bits only
			row_cfg(64'hFFFF_FFFF_FFFF_FFC1, 256'hFF),
			row_known(8'hFF, 1'b0, 1'b1, 0, 1),
			row_known(8'hDF, 1'b0, 1'b0, 0, 1),
			row_known(8'hFF, 1'b1, 1'b1, 2, 2),
			// length above the maximum is clipped; zero window must not match
			row_cfg(64'h3F, '0),
			row_known(8'h00, 1'b0, 1'b0, 0, 0),
			row_beat(8'h00, 1'b1)
		};
		foreach (plan[i]) begin
			if (plan[i].reprogram) begin
				settle();
				program_pattern(plan[i].len_word, plan[i].pat);
			end else begin
				push_text(plan[i].b, plan[i].last, plan[i].typed, plan[i].want);
			end
		end

		run_phase(17, 50);
		run_phase(50, 17);
		run_phase(0, 0);

		settle();
		repeat (8) @(posedge clk);
		if (fault_count == 0) begin
			$display("case_insensitive_substring_matcher verification clean");
		end else begin
			$display("case_insensitive_substring_matcher verification failed");
		end
		$finish;
	end

endmodule
